@@ rtl/core/plcd_pkg.sv @@
// ----------------------------------------------------------------------------
// plcd_pkg
// Shared types, geometry constants and opcodes of the page LCD controller.
// ----------------------------------------------------------------------------
package plcd_pkg;

  // Panel geometry: columns by pages of 8 pixel rows
  localparam int unsigned NumColumns = 84;
  localparam int unsigned NumPages   = 6;
  localparam int unsigned ColW       = 7;
  localparam int unsigned PageW      = 3;
  localparam int unsigned RamDepth   = NumColumns * NumPages;
  localparam int unsigned AddrW      = $clog2(RamDepth);

  // Opcode masks and codes
  localparam logic [7:0] OpNop       = 8'h00;
  localparam logic [7:0] FnSetMask   = 8'hF8;
  localparam logic [7:0] FnSetCode   = 8'h20;
  localparam logic [7:0] SetPageMask = 8'hF8;
  localparam logic [7:0] SetPageCode = 8'h40;
  localparam logic [7:0] DispMask    = 8'hFA;
  localparam logic [7:0] DispCode    = 8'h08;
  localparam logic [7:0] BiasMask    = 8'hF8;
  localparam logic [7:0] BiasCode    = 8'h10;
  localparam logic [7:0] TcMask      = 8'hFC;
  localparam logic [7:0] TcCode      = 8'h04;

  typedef enum logic {
    ActSerial = 1'b0,
    ActRead   = 1'b1
  } action_e;

  typedef struct packed {
    logic             action;
    logic             is_data;
    logic [7:0]       byte_in;
    logic [ColW-1:0]  read_column;
    logic [PageW-1:0] read_page;
  } in_t;

  typedef struct packed {
    logic [7:0]       read_byte;
    logic [ColW-1:0]  column_now;
    logic [PageW-1:0] page_now;
    logic             extended_set;
    logic             vertical_mode;
    logic             powered_down;
    logic [1:0]       display_mode;
    logic [6:0]       contrast;
    logic [2:0]       bias_level;
    logic [1:0]       temp_coeff;
  } out_t;

  // Controller register file
  typedef struct packed {
    logic [ColW-1:0]  col;
    logic [PageW-1:0] page;
    logic             ext;
    logic             vert;
    logic             pd;
    logic [1:0]       mode;
    logic [6:0]       vop;
    logic [2:0]       bias;
    logic [1:0]       tc;
  } state_t;

  // Display RAM access request
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  function automatic logic [AddrW-1:0] ram_addr(logic [PageW-1:0] page,
                                               logic [ColW-1:0] col);
    return AddrW'(AddrW'(page) * AddrW'(NumColumns) + AddrW'(col));
  endfunction

  function automatic logic col_ok(logic [ColW-1:0] col);
    return {1'b0, col} < (ColW + 1)'(NumColumns);
  endfunction

  function automatic logic page_ok(logic [PageW-1:0] page);
    return {1'b0, page} < (PageW + 1)'(NumPages);
  endfunction

endpackage

@@ rtl/core/plcd_ram.sv @@
// ----------------------------------------------------------------------------
// plcd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module plcd_ram #(
  parameter int unsigned Depth = 504,
  parameter int unsigned Width = 8,
  parameter int unsigned AW    = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/plcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// plcd_ctrl
// Command decoder, address counter and RAM access generation.
// ----------------------------------------------------------------------------
module plcd_ctrl
  import plcd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_t      item_i,
  output mem_req_t mem_req_o,
  output state_t   state_o
);

  localparam state_t StateRst = '{col: '0, page: '0, ext: 1'b0, vert: 1'b0,
                                  pd: 1'b1, mode: '0, vop: '0, bias: '0,
                                  tc: '0};

  state_t st_q, st_d;
  logic   is_read;
  logic   is_write;
  logic   is_cmd;
  logic   last_col;
  logic   last_page;
  logic [7:0] b;

  assign b         = item_i.byte_in;
  assign is_read   = accept_i && (item_i.action == ActRead);
  assign is_write  = accept_i && (item_i.action == ActSerial) && item_i.is_data;
  assign is_cmd    = accept_i && (item_i.action == ActSerial) && !item_i.is_data;
  assign last_col  = (st_q.col == ColW'(NumColumns - 1));
  assign last_page = (st_q.page == PageW'(NumPages - 1));

  always_comb begin
    st_d = st_q;
    if (is_write) begin
      // advance the write pointer, wrapping into the next page or column
      if (st_q.vert) begin
        if (last_page) begin
          st_d.page = '0;
          st_d.col  = last_col ? '0 : st_q.col + ColW'(1);
        end else begin
          st_d.page = st_q.page + PageW'(1);
        end
      end else begin
        if (last_col) begin
          st_d.col  = '0;
          st_d.page = last_page ? '0 : st_q.page + PageW'(1);
        end else begin
          st_d.col = st_q.col + ColW'(1);
        end
      end
    end else if (is_cmd && (b != OpNop)) begin
      if ((b & FnSetMask) == FnSetCode) begin
        st_d.pd   = b[2];
        st_d.vert = b[1];
        st_d.ext  = b[0];
      end else if (!st_q.ext) begin
        if (b[7]) begin
          if (col_ok(b[ColW-1:0])) begin
            st_d.col = b[ColW-1:0];
          end
        end else if ((b & SetPageMask) == SetPageCode) begin
          if (page_ok(b[PageW-1:0])) begin
            st_d.page = b[PageW-1:0];
          end
        end else if ((b & DispMask) == DispCode) begin
          st_d.mode = {b[0], b[2]};
        end
      end else begin
        if (b[7]) begin
          st_d.vop = b[6:0];
        end else if ((b & BiasMask) == BiasCode) begin
          st_d.bias = b[2:0];
        end else if ((b & TcMask) == TcCode) begin
          st_d.tc = b[1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateRst;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    mem_req_o.we    = is_write && col_ok(st_q.col) && page_ok(st_q.page);
    mem_req_o.waddr = ram_addr(st_q.page, st_q.col);
    mem_req_o.wdata = b;
    mem_req_o.re    = is_read && col_ok(item_i.read_column) && page_ok(item_i.read_page);
    mem_req_o.raddr = ram_addr(item_i.read_page, item_i.read_column);
  end

  assign state_o = st_q;

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_ok(st_q.col))
    else $error("column address out of range");

  a_page_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    page_ok(st_q.page))
    else $error("page address out of range");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(st_q))
    else $error("register file changed without a transfer");

  a_read_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_read |=> $stable(st_q))
    else $error("scan read changed controller state");

  a_wr_rd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req_o.we && mem_req_o.re))
    else $error("RAM write and read issued for one transfer");

endmodule

@@ rtl/core/page_lcd_command_and_ram_controller_core.sv @@
// ----------------------------------------------------------------------------
// page_lcd_command_and_ram_controller_core
// Command and display RAM controller for a page-organized monochrome LCD.
// ----------------------------------------------------------------------------
// A transfer accepted at one clock edge yields its result, with done_o high,
// in the very next cycle, and a new item may be accepted at every edge, so
// busy stays low. read_byte comes from the registered read port of the
// display RAM; a data byte is written to the RAM in the cycle it is accepted,
// and a scan read issued in the next cycle already sees it. read_byte is zero
// for serial bytes and for reads outside the panel. The receiver cannot
// stall: each result is shown for one cycle.
module page_lcd_command_and_ram_controller_core
  import plcd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  in_i,
  output logic done_o,
  output out_t result_o
);

  logic     accept;
  mem_req_t mem_req;
  state_t   state;
  logic [7:0] rdata;
  logic     done_q;
  logic     rd_ok_q;

  // one item per cycle, never stall the sender
  assign busy   = 1'b0;
  assign accept = start && !busy;

  plcd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (in_i),
    .mem_req_o (mem_req),
    .state_o   (state)
  );

  plcd_ram #(
    .Depth (RamDepth),
    .Width (8),
    .AW    (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      rd_ok_q <= 1'b0;
    end else begin
      done_q  <= accept;
      rd_ok_q <= mem_req.re;
    end
  end

  always_comb begin
    result_o.read_byte     = rd_ok_q ? rdata : 8'h00;
    result_o.column_now    = state.col;
    result_o.page_now      = state.page;
    result_o.extended_set  = state.ext;
    result_o.vertical_mode = state.vert;
    result_o.powered_down  = state.pd;
    result_o.display_mode  = state.mode;
    result_o.contrast      = state.vop;
    result_o.bias_level    = state.bias;
    result_o.temp_coeff    = state.tc;
  end

  assign done_o = done_q;

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("result strobe missing after transfer");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result strobe without transfer");

  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rd_ok_q) |-> (result_o.read_byte == 8'h00))
    else $error("read_byte nonzero without a RAM read");

endmodule
